// File: rtl/core/mthp_pkg.sv
// Shared types and constants for the media tag header packer.
// Holds the tag kind codes, the sample rate table and the header record.
// No dependencies.
`default_nettype none

package mthp_pkg;

    typedef enum logic [1:0] {
        OP_AUDIO = 2'd0,
        OP_VIDEO = 2'd1,
        OP_DATA  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int HDR_MAX    = 9;
    localparam int IDX_W      = 4;
    localparam int RATE_COUNT = 26;
    localparam int RATE_W     = 23;

    localparam logic [7:0] AUDIO_MARK = 8'h80;
    localparam logic [7:0] VIDEO_MARK = 8'hC0;
    localparam logic [7:0] TRACK_MARK = 8'h40;

    localparam logic [RATE_W-1:0] RATE_TABLE [RATE_COUNT] = '{
        23'd0,      23'd5512,   23'd7350,   23'd8000,   23'd11025,
        23'd12000,  23'd16000,  23'd18900,  23'd22050,  23'd24000,
        23'd32000,  23'd37800,  23'd44056,  23'd44100,  23'd47250,
        23'd48000,  23'd50000,  23'd50400,  23'd64000,  23'd88200,
        23'd96000,  23'd176400, 23'd192000, 23'd352800, 23'd2822400,
        23'd5644800
    };

    // Header bytes left-aligned: the highest byte index goes out first.
    typedef struct packed {
        logic [HDR_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]        last_idx;
    } hdr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Unknown rates map to index 0.
    function automatic logic [4:0] rate_index(input logic [RATE_W-1:0] hz);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 1; i < RATE_COUNT; i++) begin
            if (RATE_TABLE[i] == hz)
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mthp_front.sv
// Front stage: accepts a tag descriptor, looks up the rate index and
// builds the left-aligned header record. Depends on mthp_pkg.
`default_nettype none

module mthp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        operation,
    input  wire logic [5:0]        codec,
    input  wire logic [7:0]        channels,
    input  wire logic [22:0]       sample_rate,
    input  wire logic              is_config,
    input  wire logic [4:0]        frame,
    input  wire logic [15:0]       comp_offset,
    input  wire logic [7:0]        track,
    input  wire logic [31:0]       timestamp,
    input  wire logic [5:0]        data_type,
    output logic                   hdr_valid,
    input  wire logic              hdr_ready,
    output mthp_pkg::hdr_t         hdr
);

    logic           vld_reg;
    logic           vld_next;
    mthp_pkg::hdr_t hdr_reg;
    mthp_pkg::hdr_t hdr_next;
    logic           accept;
    logic           trk_on;
    logic           offs_on;
    logic [7:0]     a_b0;
    logic [7:0]     a_b2;
    logic [7:0]     v_b0;
    logic [7:0]     v_b1;
    logic [7:0]     d_b0;

    assign in_ready  = !vld_reg || hdr_ready;
    assign accept    = in_valid && in_ready;
    assign hdr_valid = vld_reg;
    assign hdr       = hdr_reg;

    assign offs_on = (comp_offset != 16'd0);
    assign a_b0    = mthp_pkg::AUDIO_MARK | {2'b00, codec};
    assign a_b2    = {mthp_pkg::rate_index(sample_rate), 1'b0, is_config, (track != 8'd1)};
    assign v_b0    = mthp_pkg::VIDEO_MARK | {2'b00, codec};
    assign v_b1    = {frame, 1'b0, offs_on, (track != 8'd1)};
    assign d_b0    = {2'b00, data_type};

    always_comb
    begin
        hdr_next = hdr_reg;
        trk_on   = 1'b0;
        case (mthp_pkg::op_t'(operation))
            mthp_pkg::OP_AUDIO:
            begin
                trk_on = (track != 8'd1);
                if (trk_on)
                begin
                    hdr_next.bytes    = {a_b0, channels, a_b2, track, timestamp, 8'h00};
                    hdr_next.last_idx = 4'd7;
                end
                else
                begin
                    hdr_next.bytes    = {a_b0, channels, a_b2, timestamp, 16'h0000};
                    hdr_next.last_idx = 4'd6;
                end
            end
            mthp_pkg::OP_VIDEO:
            begin
                trk_on = (track != 8'd1);
                case ({offs_on, trk_on})
                    2'b00:
                    begin
                        hdr_next.bytes    = {v_b0, v_b1, timestamp, 24'h000000};
                        hdr_next.last_idx = 4'd5;
                    end
                    2'b01:
                    begin
                        hdr_next.bytes    = {v_b0, v_b1, track, timestamp, 16'h0000};
                        hdr_next.last_idx = 4'd6;
                    end
                    2'b10:
                    begin
                        hdr_next.bytes    = {v_b0, v_b1, comp_offset, timestamp, 8'h00};
                        hdr_next.last_idx = 4'd7;
                    end
                    default:
                    begin
                        hdr_next.bytes    = {v_b0, v_b1, comp_offset, track, timestamp};
                        hdr_next.last_idx = 4'd8;
                    end
                endcase
            end
            mthp_pkg::OP_DATA:
            begin
                trk_on = (track != 8'd0);
                if (trk_on)
                begin
                    hdr_next.bytes    = {mthp_pkg::TRACK_MARK | d_b0, track, 56'h0};
                    hdr_next.last_idx = 4'd1;
                end
                else
                begin
                    hdr_next.bytes    = {d_b0, 64'h0};
                    hdr_next.last_idx = 4'd0;
                end
            end
            default:
            begin
                hdr_next = hdr_reg;
            end
        endcase
    end

    // Drop the unused kind: it produces no header.
    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = (mthp_pkg::op_t'(operation) != mthp_pkg::OP_NONE);
        end
        else if (hdr_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mthp_queue.sv
// Header queue between front and back stages, show-ahead read.
// Depends on mthp_pkg.
`default_nettype none

module mthp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mthp_pkg::hdr_t push_hdr,
    input  wire logic           pop,
    output mthp_pkg::hdr_t      head,
    output mthp_pkg::q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mthp_pkg::hdr_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_hdr;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mthp_back.sv
// Back stage, depends on mthp_pkg: walks the head header one byte per cycle,
// unless out_ready stalls it, into the output register; pops the queue on the final byte.
`default_nettype none

module mthp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mthp_pkg::hdr_t head,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                last
);

    logic                       vld_reg;
    logic                       vld_next;
    logic [7:0]                 byte_reg;
    logic                       last_reg;
    logic [mthp_pkg::IDX_W-1:0] idx_reg;
    logic [mthp_pkg::IDX_W-1:0] idx_next;
    logic                       load;
    logic                       at_end;

    assign load   = head_valid && (!vld_reg || out_ready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (load)
        begin
            vld_next = 1'b1;
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[mthp_pkg::IDX_W'(mthp_pkg::HDR_MAX - 1) - idx_reg];
            last_reg <= at_end;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/media_tag_header_packer.sv
// Top level of the media tag header packer.
// Instantiates mthp_front, mthp_queue and mthp_back; depends on mthp_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready) takes one tag descriptor per item:
//   operation selects audio, video or data; fields of other kinds are
//   ignored. Operation 3 is dropped and produces no bytes.
//   Output channel (out_valid/out_ready) gives the header one byte per
//   item, most significant byte first for multi-byte fields, with last
//   set on the final byte: audio 7-8 bytes, video 6-9, data 1-2.
// Path: a descriptor passes the front register and the header queue before
//   its first byte is loaded into the output byte register.
// Throughput: one byte per cycle while out_ready is high, set by the single
//   output byte register in the back stage. The front stage builds the next
//   header while the back stage is still sending.
// Stall: when out_ready is low the byte register holds; the queue fills
//   (QUEUE_DEPTH headers), then the front register, then in_ready drops.
// Reset: rst_n clears all valid flags and pointers; nothing is in flight
//   afterwards and no clearing pass is needed.

module media_tag_header_packer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [5:0]  codec,
    input  wire logic [7:0]  channels,
    input  wire logic [22:0] sample_rate,
    input  wire logic        is_config,
    input  wire logic [4:0]  frame,
    input  wire logic [15:0] comp_offset,
    input  wire logic [7:0]  track,
    input  wire logic [31:0] timestamp,
    input  wire logic [5:0]  data_type,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last
);

    logic                 front_valid;
    logic                 q_push;
    logic                 q_pop;
    mthp_pkg::hdr_t       front_hdr;
    mthp_pkg::hdr_t       q_head;
    mthp_pkg::q_status_t  q_stat;

    // Hand a header to the queue whenever it has room.
    assign q_push = front_valid && !q_stat.full;

    mthp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .codec       (codec),
        .channels    (channels),
        .sample_rate (sample_rate),
        .is_config   (is_config),
        .frame       (frame),
        .comp_offset (comp_offset),
        .track       (track),
        .timestamp   (timestamp),
        .data_type   (data_type),
        .hdr_valid   (front_valid),
        .hdr_ready   (!q_stat.full),
        .hdr         (front_hdr)
    );

    mthp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_hdr (front_hdr),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_stat)
    );

    mthp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_stat.empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last)
    );

    // Queue cannot be full and empty at once.
    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // Back stage pops only a present header.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty header queue");

    // Every pop sends a byte flagged last on the next cycle.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last))
        else $error("header popped without a final byte");

    // Unused kind leaves nothing in the front register.
    a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == mthp_pkg::OP_NONE)) |=> !front_valid)
        else $error("unused tag kind was not dropped");

endmodule

`default_nettype wire

// File: bench/media_tag_header_packer_tb.sv
// Testbench for media_tag_header_packer: feeds audio, video, data and unused tag
// descriptors and checks every header byte and its last flag against a local packer.
// Depends on mthp_pkg (op_t) and the media_tag_header_packer RTL.
`default_nettype none

module media_tag_header_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Long enough for every item to carry a 9-byte header through the slowest
    // stall phase, with margin several times over.
    localparam int LIMIT_NS    = 1_500_000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_GAP     = 16;

    // Leading marks of each header kind.
    localparam logic [7:0] AUDIO_LEAD = 8'h80;
    localparam logic [7:0] VIDEO_LEAD = 8'hC0;
    localparam logic [7:0] DATA_TRACK = 8'h40;

    // Sample rates in index order; anything else encodes as index 0.
    localparam int RATE_SLOTS = 26;
    localparam logic [22:0] KNOWN_RATES [RATE_SLOTS] = '{
        23'd0,      23'd5512,   23'd7350,   23'd8000,   23'd11025,
        23'd12000,  23'd16000,  23'd18900,  23'd22050,  23'd24000,
        23'd32000,  23'd37800,  23'd44056,  23'd44100,  23'd47250,
        23'd48000,  23'd50000,  23'd50400,  23'd64000,  23'd88200,
        23'd96000,  23'd176400, 23'd192000, 23'd352800, 23'd2822400,
        23'd5644800
    };

    typedef struct {
        mthp_pkg::op_t op;
        logic [5:0]    codec;
        logic [7:0]    channels;
        logic [22:0]   sample_rate;
        logic          is_config;
        logic [4:0]    frame;
        logic [15:0]   comp_offset;
        logic [7:0]    track;
        logic [31:0]   timestamp;
        logic [5:0]    data_type;
    } tag_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } hdr_byte_t;

    // Packs each accepted tag into its header bytes and matches the bytes
    // leaving the block against them in order.
    class header_scoreboard;
        hdr_byte_t expected_q[$];
        int        errors;
        int        checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function logic [4:0] rate_code(logic [22:0] hz);
            logic [4:0] code;
            code = 5'd0;
            for (int i = 1; i < RATE_SLOTS; i++)
            begin
                if (KNOWN_RATES[i] == hz)
                begin
                    code = 5'(i);
                end
            end
            return code;
        endfunction

        function void note_tag(tag_t t);
            logic [7:0] hdr[$];
            hdr_byte_t  e;
            case (t.op)
                mthp_pkg::OP_AUDIO:
                begin
                    hdr.push_back(AUDIO_LEAD | {2'b00, t.codec});
                    hdr.push_back(t.channels);
                    hdr.push_back({rate_code(t.sample_rate), 1'b0, t.is_config,
                                   t.track != 8'd1});
                    if (t.track != 8'd1)
                    begin
                        hdr.push_back(t.track);
                    end
                end
                mthp_pkg::OP_VIDEO:
                begin
                    hdr.push_back(VIDEO_LEAD | {2'b00, t.codec});
                    hdr.push_back({t.frame, 1'b0, t.comp_offset != 16'd0, t.track != 8'd1});
                    if (t.comp_offset != 16'd0)
                    begin
                        hdr.push_back(t.comp_offset[15:8]);
                        hdr.push_back(t.comp_offset[7:0]);
                    end
                    if (t.track != 8'd1)
                    begin
                        hdr.push_back(t.track);
                    end
                end
                mthp_pkg::OP_DATA:
                begin
                    if (t.track == 8'd0)
                    begin
                        hdr.push_back({2'b00, t.data_type});
                    end
                    else
                    begin
                        hdr.push_back(DATA_TRACK | {2'b00, t.data_type});
                        hdr.push_back(t.track);
                    end
                end
                default:
                begin
                    // unused kind: dropped without output
                end
            endcase
            // audio and video always close with the time, high byte first
            if (t.op == mthp_pkg::OP_AUDIO || t.op == mthp_pkg::OP_VIDEO)
            begin
                hdr.push_back(t.timestamp[31:24]);
                hdr.push_back(t.timestamp[23:16]);
                hdr.push_back(t.timestamp[15:8]);
                hdr.push_back(t.timestamp[7:0]);
            end
            for (int i = 0; i < hdr.size(); i++)
            begin
                e.value = hdr[i];
                e.last  = (i == hdr.size() - 1);
                expected_q.push_back(e);
            end
        endfunction

        function void check_byte(logic [7:0] value, logic last_flag);
            hdr_byte_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: byte %h last %b arrived with nothing expected",
                         $realtime, value, last_flag);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.value !== value)
                begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $realtime, e.value, value);
                end
                if (e.last !== last_flag)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $realtime, e.last, last_flag);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [5:0]  codec;
    logic [7:0]  channels;
    logic [22:0] sample_rate;
    logic        is_config;
    logic [4:0]  frame;
    logic [15:0] comp_offset;
    logic [7:0]  track;
    logic [31:0] timestamp;
    logic [5:0]  data_type;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last;

    header_scoreboard board;

    // Idling knobs, percent of cycles; hold_req asks the receiver for one long hold-off.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;

    // Coverage counters for the closing summary.
    int kind_count [4];
    int blocked_cycles = 0;

    media_tag_header_packer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .codec       (codec),
        .channels    (channels),
        .sample_rate (sample_rate),
        .is_config   (is_config),
        .frame       (frame),
        .comp_offset (comp_offset),
        .track       (track),
        .timestamp   (timestamp),
        .data_type   (data_type),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: end the run if the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Input monitor: the payload held at an accepting edge is the item.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            board.note_tag('{mthp_pkg::op_t'(operation), codec, channels, sample_rate,
                             is_config, frame, comp_offset, track, timestamp, data_type});
            kind_count[operation]++;
        end
        if (rst_n && in_valid && !in_ready)
        begin
            blocked_cycles++;
        end
    end

    // Output monitor: check every accepted byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_byte(out_byte, last);
        end
    end

    // Receiver: stall at the phase rate; on request hold off for a long stretch so
    // the queue fills and in_ready drops while the sender keeps offering items.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic tag_t make_tag(mthp_pkg::op_t op, logic [5:0] cd, logic [7:0] ch,
                                      logic [22:0] hz, logic cfg, logic [4:0] fr,
                                      logic [15:0] offs, logic [7:0] trk,
                                      logic [31:0] ts, logic [5:0] dt);
        tag_t t;
        t = '{op, cd, ch, hz, cfg, fr, offs, trk, ts, dt};
        return t;
    endfunction

    function automatic tag_t random_tag();
        tag_t t;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 38)
            t.op = mthp_pkg::OP_AUDIO;
        else if (pick < 76)
            t.op = mthp_pkg::OP_VIDEO;
        else if (pick < 95)
            t.op = mthp_pkg::OP_DATA;
        else
            t.op = mthp_pkg::OP_NONE;
        t.codec     = 6'($urandom);
        t.channels  = 8'($urandom);
        t.is_config = 1'($urandom);
        t.frame     = 5'($urandom);
        t.timestamp = $urandom;
        t.data_type = 6'($urandom);
        // table rates in two of five draws, plus near misses and arbitrary values
        case ($urandom_range(4))
            0, 1: t.sample_rate = KNOWN_RATES[$urandom_range(RATE_SLOTS - 1)];
            2:    t.sample_rate = KNOWN_RATES[$urandom_range(RATE_SLOTS - 1)]
                                  + ($urandom_range(1) ? 23'd1 : -23'd1);
            3:    t.sample_rate = 23'($urandom);
            default: t.sample_rate = 23'($urandom_range(5644800));
        endcase
        // lean on the track values that switch the optional byte
        case ($urandom_range(3))
            0:       t.track = 8'd0;
            1:       t.track = 8'd1;
            default: t.track = 8'($urandom);
        endcase
        t.comp_offset = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        return t;
    endfunction

    // Offer one item, hold it until accepted, then idle at the phase rate.
    task automatic send_tag(input tag_t t);
        int gap;
        gap = 0;
        in_valid    <= 1'b1;
        operation   <= t.op;
        codec       <= t.codec;
        channels    <= t.channels;
        sample_rate <= t.sample_rate;
        is_config   <= t.is_config;
        frame       <= t.frame;
        comp_offset <= t.comp_offset;
        track       <= t.track;
        timestamp   <= t.timestamp;
        data_type   <= t.data_type;
        do
            @(posedge clk);
        while (!in_ready);
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_tag(random_tag());
    endtask

    initial
    begin
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = mthp_pkg::OP_AUDIO;
        codec       = '0;
        channels    = '0;
        sample_rate = '0;
        is_config   = 1'b0;
        frame       = '0;
        comp_offset = '0;
        track       = '0;
        timestamp   = '0;
        data_type   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every kind, optional bytes on and off,
        // unknown rates, the unused kind and fields foreign to the kind.
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd1,
                          32'd0, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd63, 8'd255, 23'd5644800, 1'b1, 5'd31,
                          16'hFFFF, 8'd255, 32'hFFFF_FFFF, 6'd63));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd21, 8'd2, 23'd5512, 1'b0, 5'd0, 16'd0,
                          8'd0, 32'h0102_0304, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd10, 8'd6, 23'd44056, 1'b1, 5'd0, 16'd0,
                          8'd2, 32'h8000_0001, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd42, 8'd1, 23'd44057, 1'b1, 5'd0, 16'd0,
                          8'd1, 32'h7FFF_FFFF, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd1, 8'd128, 23'h7F_FFFF, 1'b0, 5'd0, 16'd0,
                          8'd7, 32'hDEAD_BEEF, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd5, 8'd8, 23'd7350, 1'b0, 5'd0, 16'd0,
                          8'd1, 32'd1, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_AUDIO, 6'd5, 8'd8, 23'd2822400, 1'b1, 5'd0, 16'd0,
                          8'd1, 32'd1, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_VIDEO, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd1,
                          32'd0, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_VIDEO, 6'd63, 8'd255, 23'h7F_FFFF, 1'b1, 5'd31,
                          16'hFFFF, 8'd0, 32'hFFFF_FFFF, 6'd63));
        send_tag(make_tag(mthp_pkg::OP_VIDEO, 6'd7, 8'd0, 23'd0, 1'b0, 5'd16, 16'd1, 8'd1,
                          32'h0000_FF00, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_VIDEO, 6'd12, 8'd0, 23'd0, 1'b0, 5'd1, 16'd0,
                          8'd200, 32'h00FF_0000, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_VIDEO, 6'd33, 8'd0, 23'd0, 1'b0, 5'd9, 16'h8000,
                          8'd2, 32'h1234_5678, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_DATA, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd0,
                          32'd0, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_DATA, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd255,
                          32'd0, 6'd63));
        send_tag(make_tag(mthp_pkg::OP_DATA, 6'd63, 8'd255, 23'd48000, 1'b1, 5'd31,
                          16'hFFFF, 8'd0, 32'hFFFF_FFFF, 6'd63));
        send_tag(make_tag(mthp_pkg::OP_DATA, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd1,
                          32'd0, 6'd0));
        send_tag(make_tag(mthp_pkg::OP_NONE, 6'd63, 8'd255, 23'd44100, 1'b1, 5'd31,
                          16'hFFFF, 8'd255, 32'hFFFF_FFFF, 6'd63));
        send_tag(make_tag(mthp_pkg::OP_DATA, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd3,
                          32'd0, 6'd21));
        send_tag(make_tag(mthp_pkg::OP_NONE, 6'd0, 8'd0, 23'd0, 1'b0, 5'd0, 16'd0, 8'd0,
                          32'd0, 6'd0));

        // Random phases: free flow, a long receiver hold-off with the sender
        // pushing, then sender gaps, receiver stalls and both together.
        run_phase(100, 0, 0);
        hold_req = 1'b1;
        run_phase(30, 0, 0);
        run_phase(90, 60, 0);
        run_phase(90, 0, 60);
        run_phase(90, 20, 20);
        in_valid <= 1'b0;

        // Drain, then give stray bytes a chance to show up.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Covered %0d audio, %0d video, %0d data and %0d unused-kind tags;",
                 kind_count[mthp_pkg::OP_AUDIO], kind_count[mthp_pkg::OP_VIDEO],
                 kind_count[mthp_pkg::OP_DATA], kind_count[mthp_pkg::OP_NONE]);
        $display("checked %0d header bytes, input held off for %0d cycles.",
                 board.checked, blocked_cycles);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/mthp_pkg.sv
rtl/core/mthp_front.sv
rtl/core/mthp_queue.sv
rtl/core/mthp_back.sv
rtl/core/media_tag_header_packer.sv
bench/media_tag_header_packer_tb.sv
